// ===== src/cdq_pkg.sv =====
package cdq_pkg;

	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_REAR  = 2'd1,
		FN_POP_FRONT  = 2'd2,
		FN_POP_REAR   = 2'd3
	} cdq_func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} cdq_status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                    en;     // accepted, not refused
		cdq_func_t               fn;
		logic signed [DATA_W-1:0] wdata;
	} cdq_ctl_t;

endpackage

// ===== src/cdq_cell.sv =====
module cdq_cell
	import cdq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cdq_ctl_t                 ctl,
	input  logic signed [DATA_W-1:0] prev_data,
	input  logic                     prev_valid,
	input  logic signed [DATA_W-1:0] next_data,
	input  logic                     next_valid,
	output logic signed [DATA_W-1:0] data,
	output logic                     valid,
	output logic signed [DATA_W-1:0] tail_tap
);

	logic signed [DATA_W-1:0] data_q;
	logic                     valid_q;
	logic signed [DATA_W-1:0] data_d;
	logic                     valid_d;
	logic                     is_tail;

	assign is_tail = valid_q && !next_valid;

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		if (ctl.en) begin
			unique case (ctl.fn)
				FN_PUSH_FRONT: begin
					data_d  = prev_data;
					valid_d = prev_valid;
				end
				FN_PUSH_REAR: begin
					// first free cell takes the word
					if (prev_valid && !valid_q) begin
						data_d  = ctl.wdata;
						valid_d = 1'b1;
					end
				end
				FN_POP_FRONT: begin
					data_d  = next_data;
					valid_d = next_valid;
				end
				FN_POP_REAR: begin
					if (is_tail) begin
						valid_d = 1'b0;
					end
				end
				default: begin
					data_d  = data_q;
					valid_d = valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data     = data_q;
	assign valid    = valid_q;
	assign tail_tap = is_tail ? data_q : '0;

endmodule

// ===== src/circular_deque.sv =====
// Channel  Handshake             Payload
// -------  --------------------  ---------------------------------------------
// in       in_valid / in_ready    func, data_in
// out      out_valid / out_ready  data_out, status, occupancy, is_empty, is_full
//
// One operation per cycle while in_ready is high; each result shows in the
// cycle after its transfer in. The entries sit in a row of cells, packed from
// cell 0 (front) upward; a front push or pop moves every cell by one place.
// Reset clears the count, the cell valid bits and the output valid flag.
// in_ready is low only while a result waits and out_ready is low.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] data_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] data_out,
	output logic [STATUS_W-1:0]      status,
	output logic [OCC_W-1:0]         occupancy,
	output logic                     is_empty,
	output logic                     is_full
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// occupancy count, kept beside the cell valid bits
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	logic                     in_xfer;
	cdq_func_t                fn;
	logic                     cur_empty;
	logic                     cur_full;
	logic                     refuse;
	cdq_status_t              status_d;
	logic signed [DATA_W-1:0] pop_data;
	logic signed [DATA_W-1:0] rear_data;
	cdq_ctl_t                 ctl;

	// cell row
	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] cell_tap  [DEPTH];
	logic [DEPTH-1:0]         cell_valid;

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] data_out_q;
	cdq_status_t              status_q;
	logic [OCC_W-1:0]         occ_q;
	logic                     empty_q;
	logic                     full_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign fn        = cdq_func_t'(func);
	assign cur_empty = (count_q == '0);
	assign cur_full  = (count_q == CNT_W'(DEPTH));

	always_comb begin
		refuse   = 1'b0;
		status_d = ST_DONE;
		unique case (fn)
			FN_PUSH_FRONT, FN_PUSH_REAR: begin
				if (cur_full) begin
					refuse   = 1'b1;
					status_d = ST_FULL;
				end
			end
			FN_POP_FRONT, FN_POP_REAR: begin
				if (cur_empty) begin
					refuse   = 1'b1;
					status_d = ST_EMPTY;
				end
			end
			default: begin
				refuse   = 1'b0;
				status_d = ST_DONE;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (in_xfer && !refuse) begin
			if (fn == FN_PUSH_FRONT || fn == FN_PUSH_REAR) begin
				count_d = count_q + CNT_W'(1);
			end else begin
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	assign ctl.en    = in_xfer && !refuse;
	assign ctl.fn    = fn;
	assign ctl.wdata = data_in;

	// each cell drives its word only when it is the rear; OR them together
	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_data = rear_data | cell_tap[i];
		end
	end

	always_comb begin
		pop_data = '0;
		if (!refuse) begin
			if (fn == FN_POP_FRONT) begin
				pop_data = cell_data[0];
			end else if (fn == FN_POP_REAR) begin
				pop_data = rear_data;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] prev_d;
		logic                     prev_v;
		logic signed [DATA_W-1:0] next_d;
		logic                     next_v;

		if (g == 0) begin : g_head
			assign prev_d = data_in;
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_d = cell_data[g-1];
			assign prev_v = cell_valid[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_d = '0;
			assign next_v = 1'b0;
		end else begin : g_inner
			assign next_d = cell_data[g+1];
			assign next_v = cell_valid[g+1];
		end

		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_data  (prev_d),
			.prev_valid (prev_v),
			.next_data  (next_d),
			.next_valid (next_v),
			.data       (cell_data[g]),
			.valid      (cell_valid[g]),
			.tail_tap   (cell_tap[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_out_q <= pop_data;
			status_q   <= status_d;
			occ_q      <= OCC_W'(count_d);
			empty_q    <= (count_d == '0);
			full_q     <= (count_d == CNT_W'(DEPTH));
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign occupancy = occ_q;
	assign is_empty  = empty_q;
	assign is_full   = full_q;

`ifndef SYNTH
	// cells hold a packed run from cell 0 that matches the count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("cell valid bits disagree with count");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_valid ^ (cell_valid >> 1)))
		else $error("cell valid bits not packed from the front");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count beyond depth");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (fn == FN_POP_FRONT || fn == FN_POP_REAR) && !cur_empty)
		|=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not decrement count");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FULL) |-> (full_q && data_out_q == '0))
		else $error("full refusal with inconsistent result");
`endif

endmodule
